// ----- src/kabf_pkg.sv -----
// Shared widths, register indexes and saturation helpers for the angle/bias Kalman filter.
package kabf_pkg;

  localparam int unsigned InTdataW  = 88;
  localparam int unsigned OutTdataW = 80;
  localparam int unsigned CfgW      = 32;
  localparam int unsigned CfgIdxW   = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ANGLE_NOISE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BIAS_NOISE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MEAS_NOISE  = 2'd2;

  localparam logic [CfgW-1:0] ANGLE_NOISE_RST = 32'd2147484;
  localparam logic [CfgW-1:0] BIAS_NOISE_RST  = 32'd2147484;
  localparam logic [CfgW-1:0] MEAS_NOISE_RST  = 32'd1288490;

  localparam logic signed [71:0] S32_MAX = 72'sd2147483647;
  localparam logic signed [71:0] S32_MIN = -72'sd2147483648;
  localparam logic signed [71:0] S48_MAX = 72'sd140737488355327;
  localparam logic signed [71:0] S48_MIN = -72'sd140737488355328;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [71:0] v);
    logic signed [47:0] r;
    if (v > S48_MAX) begin
      r = 48'sh7fffffffffff;
    end else if (v < S48_MIN) begin
      r = 48'sh800000000000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

// ----- src/kalman_angle_bias_filter_top.sv -----
// Two-state (angle, gyro bias) Kalman filter with a shared serial multiplier and divider.
//
//  channel    dir  signals                          word layout (low bit first)
//  s_axis     in   tvalid/tready/tdata[87:0]         angle_meas, rate_meas, step_time
//  m_axis     out  tvalid/tready/tdata[79:0]         angle_whole, angle_est, bias_est
//  cfg        in   cfg_we_i/cfg_index_i/cfg_wdata_i  0 angle noise, 1 bias noise, 2 meas noise
//
// Each word runs ten multiplies (load, three 16-bit digit passes of the 51x16 multiplier,
// round, write back) and two gain divisions (one quotient bit per cycle). A saturated gain
// skips the quotient loop; a zero innovation variance skips both divisions.
// The input is ready only while the sequencer is idle; a held result does not stall the next
// word until that word finishes, then the sequencer waits for the output register to empty.
// Reset clears the estimates and covariances to zero and loads the default noise settings.
module kalman_angle_bias_filter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [kabf_pkg::InTdataW-1:0]  s_axis_tdata,   // angle_meas, rate_meas, step_time
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [kabf_pkg::OutTdataW-1:0] m_axis_tdata,   // angle_whole, angle_est, bias_est
  input  logic                           cfg_we_i,
  input  logic [kabf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [kabf_pkg::CfgW-1:0]      cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_RND, ST_WB, ST_DIV, ST_DIV_WB, ST_OUT
  } st_e;

  // Filter steps in order: predict, covariance projection, gains, correction.
  typedef enum logic [3:0] {
    OP_PRED, OP_DTBB, OP_PAA, OP_PBB, OP_K0, OP_K1,
    OP_CANG, OP_CBIAS, OP_CBA, OP_CAA, OP_CBB, OP_CAB
  } op_e;

  st_e state_q;
  op_e op_q;

  logic [31:0] apn_q, bpn_q, mn_q;
  logic signed [31:0] meas_q, rate_q;
  logic [23:0] dt_q;
  logic signed [31:0] angle_q, bias_q, y_q, k0_q, k1_q;
  logic signed [47:0] aa_q, ab_q, ba_q, bb_q;
  logic signed [48:0] dtbb_q, s_q;
  logic signed [49:0] tsum_q;

  logic [50:0] mul_a_q;
  logic [47:0] mul_b_q;
  logic        mul_neg_q, mul_sh16_q;
  logic [1:0]  mul_cnt_q;
  logic [84:0] acc_q;
  logic signed [69:0] res_q;

  logic [48:0] div_r_q, div_d_q;
  logic [30:0] div_nsh_q, div_q_q;
  logic        div_neg_q;
  logic [4:0]  div_cnt_q;

  logic                          m_tvalid_q;
  logic [kabf_pkg::OutTdataW-1:0] m_tdata_q;

  // Operand select for the multiplier
  logic signed [50:0] opa;
  logic signed [33:0] opb;
  logic               op_sh16;
  logic [50:0]        opa_mag;
  logic [33:0]        opb_mag;

  always_comb begin
    opa     = '0;
    opb     = 34'(signed'({1'b0, dt_q}));
    op_sh16 = 1'b0;
    case (op_q)
      OP_PRED:  opa = 51'(rate_q) - 51'(bias_q);
      OP_DTBB:  opa = 51'(bb_q);
      OP_PAA:   opa = 51'(dtbb_q) + 51'(tsum_q);
      OP_PBB: begin
        opa     = 51'(signed'({1'b0, bpn_q}));
        op_sh16 = 1'b1;
      end
      OP_CANG: begin
        opa = 51'(y_q);
        opb = 34'(k0_q);
      end
      OP_CBIAS: begin
        opa = 51'(y_q);
        opb = 34'(k1_q);
      end
      OP_CBA: begin
        opa = 51'(aa_q);
        opb = 34'(k1_q);
      end
      OP_CAA: begin
        opa = 51'(aa_q);
        opb = 34'(k0_q);
      end
      OP_CBB: begin
        opa = 51'(ab_q);
        opb = 34'(k1_q);
      end
      OP_CAB: begin
        opa = 51'(ab_q);
        opb = 34'(k0_q);
      end
      default: opa = '0;
    endcase
    opa_mag = opa[50] ? 51'(-opa) : 51'(opa);
    opb_mag = opb[33] ? 34'(-opb) : 34'(opb);
  end

  // Multiplier digit pass: most significant digit first
  logic [66:0] pp;
  logic [84:0] acc_next;
  assign pp       = mul_a_q * mul_b_q[47:32];
  assign acc_next = (acc_q << 16) + {18'b0, pp};

  // Round to nearest, ties toward plus infinity
  logic signed [85:0] prod_s, prod_r, prod_sh;
  always_comb begin
    prod_s  = mul_neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
    prod_r  = prod_s + (mul_sh16_q ? 86'sd32768 : 86'sd8388608);
    prod_sh = mul_sh16_q ? (prod_r >>> 16) : (prod_r >>> 24);
  end

  logic signed [71:0] res72;
  assign res72 = 72'(res_q);

  // Divider operands
  logic signed [47:0] div_num;
  logic [47:0]        n_mag;
  logic [48:0]        d_mag;
  logic [49:0]        div_t;
  logic               div_ge;
  always_comb begin
    div_num = (op_q == OP_K1) ? ba_q : aa_q;
    n_mag   = div_num[47] ? 48'(-div_num) : 48'(div_num);
    d_mag   = s_q[48] ? 49'(-s_q) : 49'(s_q);
    div_t   = {div_r_q, div_nsh_q[30]};
    div_ge  = div_t >= {1'b0, div_d_q};
  end

  logic signed [31:0] gain_val;
  assign gain_val = div_neg_q ? -$signed({1'b0, div_q_q}) : $signed({1'b0, div_q_q});

  // Truncate toward zero to whole degrees
  logic [15:0] whole;
  assign whole = angle_q[31:16] + {15'b0, angle_q[31] && (angle_q[15:0] != 16'd0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= OP_PRED;
      apn_q      <= kabf_pkg::ANGLE_NOISE_RST;
      bpn_q      <= kabf_pkg::BIAS_NOISE_RST;
      mn_q       <= kabf_pkg::MEAS_NOISE_RST;
      meas_q     <= '0;
      rate_q     <= '0;
      dt_q       <= '0;
      angle_q    <= '0;
      bias_q     <= '0;
      y_q        <= '0;
      k0_q       <= '0;
      k1_q       <= '0;
      aa_q       <= '0;
      ab_q       <= '0;
      ba_q       <= '0;
      bb_q       <= '0;
      dtbb_q     <= '0;
      s_q        <= '0;
      tsum_q     <= '0;
      mul_a_q    <= '0;
      mul_b_q    <= '0;
      mul_neg_q  <= 1'b0;
      mul_sh16_q <= 1'b0;
      mul_cnt_q  <= '0;
      acc_q      <= '0;
      res_q      <= '0;
      div_r_q    <= '0;
      div_d_q    <= '0;
      div_nsh_q  <= '0;
      div_q_q    <= '0;
      div_neg_q  <= 1'b0;
      div_cnt_q  <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          kabf_pkg::CFG_ANGLE_NOISE: apn_q <= cfg_wdata_i;
          kabf_pkg::CFG_BIAS_NOISE:  bpn_q <= cfg_wdata_i;
          kabf_pkg::CFG_MEAS_NOISE:  mn_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      // Drop the result once taken; the output state reloads it itself
      if (m_tvalid_q && m_axis_tready && state_q != ST_OUT) begin
        m_tvalid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            meas_q  <= s_axis_tdata[31:0];
            rate_q  <= s_axis_tdata[63:32];
            dt_q    <= s_axis_tdata[87:64];
            op_q    <= OP_PRED;
            state_q <= ST_LOAD;
          end
        end

        ST_LOAD: begin
          if (op_q == OP_K0 || op_q == OP_K1) begin
            if (op_q == OP_K0 && s_q == '0) begin
              // No innovation variance: no correction gain
              k0_q <= '0;
              k1_q <= '0;
              op_q <= OP_CANG;
            end else begin
              div_d_q   <= d_mag;
              div_neg_q <= div_num[47] ^ s_q[48];
              div_r_q   <= {8'b0, n_mag[47:7]};
              div_nsh_q <= {n_mag[6:0], 24'b0};
              div_cnt_q <= 5'd30;
              if ({8'b0, n_mag[47:7]} >= d_mag) begin
                div_q_q <= '1;
                state_q <= ST_DIV_WB;
              end else begin
                div_q_q <= '0;
                state_q <= ST_DIV;
              end
            end
          end else begin
            mul_a_q    <= opa_mag;
            mul_b_q    <= 48'(opb_mag);
            mul_neg_q  <= opa[50] ^ opb[33];
            mul_sh16_q <= op_sh16;
            mul_cnt_q  <= '0;
            acc_q      <= '0;
            state_q    <= ST_MUL;
          end
        end

        ST_MUL: begin
          acc_q     <= acc_next;
          mul_b_q   <= mul_b_q << 16;
          mul_cnt_q <= mul_cnt_q + 2'd1;
          if (mul_cnt_q == 2'd2) begin
            state_q <= ST_RND;
          end
        end

        ST_RND: begin
          res_q   <= prod_sh[69:0];
          state_q <= ST_WB;
        end

        ST_WB: begin
          case (op_q)
            OP_PRED: begin
              angle_q <= kabf_pkg::sat32(72'(angle_q) + res72);
              tsum_q  <= 50'(signed'({1'b0, apn_q, 8'b0})) - 50'(ab_q) - 50'(ba_q);
              op_q    <= OP_DTBB;
              state_q <= ST_LOAD;
            end
            OP_DTBB: begin
              dtbb_q  <= res_q[48:0];
              op_q    <= OP_PAA;
              state_q <= ST_LOAD;
            end
            OP_PAA: begin
              aa_q    <= kabf_pkg::sat48(72'(aa_q) + res72);
              ab_q    <= kabf_pkg::sat48(72'(ab_q) - 72'(dtbb_q));
              ba_q    <= kabf_pkg::sat48(72'(ba_q) - 72'(dtbb_q));
              op_q    <= OP_PBB;
              state_q <= ST_LOAD;
            end
            OP_PBB: begin
              bb_q    <= kabf_pkg::sat48(72'(bb_q) + res72);
              s_q     <= 49'(aa_q) + 49'(signed'({1'b0, mn_q, 8'b0}));
              y_q     <= kabf_pkg::sat32(72'(meas_q) - 72'(angle_q));
              op_q    <= OP_K0;
              state_q <= ST_LOAD;
            end
            OP_CANG: begin
              angle_q <= kabf_pkg::sat32(72'(angle_q) + res72);
              op_q    <= OP_CBIAS;
              state_q <= ST_LOAD;
            end
            OP_CBIAS: begin
              bias_q  <= kabf_pkg::sat32(72'(bias_q) + res72);
              op_q    <= OP_CBA;
              state_q <= ST_LOAD;
            end
            OP_CBA: begin
              ba_q    <= kabf_pkg::sat48(72'(ba_q) - res72);
              op_q    <= OP_CAA;
              state_q <= ST_LOAD;
            end
            OP_CAA: begin
              aa_q    <= kabf_pkg::sat48(72'(aa_q) - res72);
              op_q    <= OP_CBB;
              state_q <= ST_LOAD;
            end
            OP_CBB: begin
              bb_q    <= kabf_pkg::sat48(72'(bb_q) - res72);
              op_q    <= OP_CAB;
              state_q <= ST_LOAD;
            end
            OP_CAB: begin
              ab_q    <= kabf_pkg::sat48(72'(ab_q) - res72);
              state_q <= ST_OUT;
            end
            default: state_q <= ST_IDLE;
          endcase
        end

        ST_DIV: begin
          // One restoring quotient bit per cycle
          div_nsh_q <= div_nsh_q << 1;
          div_q_q   <= {div_q_q[29:0], div_ge};
          div_r_q   <= div_ge ? 49'(div_t - {1'b0, div_d_q}) : div_t[48:0];
          div_cnt_q <= div_cnt_q - 5'd1;
          if (div_cnt_q == 5'd0) begin
            state_q <= ST_DIV_WB;
          end
        end

        ST_DIV_WB: begin
          state_q <= ST_LOAD;
          if (op_q == OP_K0) begin
            k0_q <= gain_val;
            op_q <= OP_K1;
          end else begin
            k1_q <= gain_val;
            op_q <= OP_CANG;
          end
        end

        ST_OUT: begin
          // Hold until the output register is free
          if (!m_tvalid_q || m_axis_tready) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= {bias_q, angle_q, whole};
            state_q    <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while sequencer busy");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_r_q < div_d_q)
    else $error("divider remainder out of range");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result shown without finished sequence");

  a_zero_var: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD && op_q == OP_K0 && s_q == '0
    |=> k0_q == '0 && k1_q == '0 && op_q == OP_CANG)
    else $error("zero innovation variance not bypassed");

endmodule
